// File: rtl/core/adb_pkg.sv
// ----------------------------------------------------------------------------
// adb_pkg
// Shared types, widths and helpers of the antialiased disc blender.
// ----------------------------------------------------------------------------
package adb_pkg;

  // squared distance width and square root stage count
  localparam int D2W = 60;
  localparam int NS  = D2W / 2;
  // Q16 center and radius widths
  localparam int CW  = 36;
  localparam int RW  = 29;
  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // register indexes
  typedef enum logic [2:0] {
    REG_PREV_CX  = 3'd0,
    REG_PREV_CY  = 3'd1,
    REG_PREV_R   = 3'd2,
    REG_CUR_CX   = 3'd3,
    REG_CUR_CY   = 3'd4,
    REG_CUR_R    = 3'd5,
    REG_FRACTION = 3'd6,
    REG_COLOR    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [20:0] prev_cx;
    logic signed [20:0] prev_cy;
    logic [15:0]        prev_r;
    logic signed [20:0] cur_cx;
    logic signed [20:0] cur_cy;
    logic [15:0]        cur_r;
    logic [8:0]         fraction;
    logic [31:0]        color;
  } cfg_t;

  // one word in the queue
  typedef struct packed {
    logic [D2W-1:0] d2;
    logic           far;
    logic [31:0]    bg;
  } q_entry_t;

  typedef struct packed {
    logic [D2W-1:0] rem;
    logic [D2W-1:0] res;
  } sqrt_t;

  // one step of the bitwise integer square root
  function automatic sqrt_t isqrt_step(sqrt_t cur, int k);
    logic [D2W-1:0] bitv;
    logic [D2W:0]   trial;
    sqrt_t          nxt;
    bitv  = {{(D2W-1){1'b0}}, 1'b1} << (2 * (NS - 1 - k));
    trial = {1'b0, cur.res} + {1'b0, bitv};
    if ({1'b0, cur.rem} >= trial) begin
      nxt.rem = cur.rem - trial[D2W-1:0];
      nxt.res = (cur.res >> 1) + bitv;
    end else begin
      nxt.rem = cur.rem;
      nxt.res = cur.res >> 1;
    end
    return nxt;
  endfunction

endpackage

// File: rtl/core/adb_front.sv
// ----------------------------------------------------------------------------
// adb_front
// Disc interpolation, pixel offsets and squared distance per pixel.
// ----------------------------------------------------------------------------
module adb_front #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [COORD_BITS-1:0]    pixel_x,
  input  logic [COORD_BITS-1:0]    pixel_y,
  input  logic [31:0]              background,
  input  adb_pkg::cfg_t            cfg,
  output logic [adb_pkg::RW-1:0]   radius,
  output logic                     out_valid,
  input  logic                     out_ready,
  output adb_pkg::q_entry_t        out_data
);

  localparam int SHR = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
  localparam int SHL = (FRAC_BITS >= 8) ? 0 : 8 - FRAC_BITS;
  localparam logic signed [37:0] FAR_LIM = 38'sd536870912;

  // saturated weights
  logic [8:0]        f_sat;
  logic [8:0]        f_inv;
  logic signed [9:0] wf;
  logic signed [9:0] wp;
  assign f_sat = (cfg.fraction > 9'd256) ? 9'd256 : cfg.fraction;
  assign f_inv = 9'd256 - f_sat;
  assign wf    = $signed({1'b0, f_sat});
  assign wp    = $signed({1'b0, f_inv});

  // interpolation products, then sums in Q16
  logic signed [30:0] m_pcx, m_ccx, m_pcy, m_ccy;
  logic [24:0]        m_pr, m_cr;
  logic signed [31:0] s_cx, s_cy;
  logic [24:0]        s_r;
  logic signed [adb_pkg::CW-1:0] e_cx, e_cy;
  logic [adb_pkg::RW-1:0]        e_r;
  logic signed [adb_pkg::CW-1:0] cx, cy;

  always_ff @(posedge clk) begin
    m_pcx <= cfg.prev_cx * wp;
    m_ccx <= cfg.cur_cx * wf;
    m_pcy <= cfg.prev_cy * wp;
    m_ccy <= cfg.cur_cy * wf;
    m_pr  <= cfg.prev_r * f_inv;
    m_cr  <= cfg.cur_r * f_sat;
  end

  assign s_cx = 32'(m_pcx) + 32'(m_ccx);
  assign s_cy = 32'(m_pcy) + 32'(m_ccy);
  assign s_r  = m_pr + m_cr;
  assign e_cx = (FRAC_BITS >= 8) ? (adb_pkg::CW'(s_cx) >>> SHR) : (adb_pkg::CW'(s_cx) <<< SHL);
  assign e_cy = (FRAC_BITS >= 8) ? (adb_pkg::CW'(s_cy) >>> SHR) : (adb_pkg::CW'(s_cy) <<< SHL);
  assign e_r  = (FRAC_BITS >= 8) ? (adb_pkg::RW'(s_r) >> SHR) : (adb_pkg::RW'(s_r) << SHL);

  always_ff @(posedge clk) begin
    cx     <= e_cx;
    cy     <= e_cy;
    radius <= (e_r < adb_pkg::RW'(65536)) ? adb_pkg::RW'(65536) : e_r;
  end

  // stage handshake
  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;
  assign r4 = !v4 || out_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_stall = !r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  // input and delay stages, letting the disc settle after a register write
  logic [COORD_BITS-1:0] x1, y1, x2, y2;
  logic [31:0]           bg1, bg2, bg3, bg4;
  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      x1  <= pixel_x;
      y1  <= pixel_y;
      bg1 <= background;
    end
    if (r2 && v1) begin
      x2  <= x1;
      y2  <= y1;
      bg2 <= bg1;
    end
  end

  // offsets from the center and far test
  logic signed [37:0] dx_c, dy_c;
  logic               far_c;
  logic signed [29:0] dx3, dy3;
  logic               far3, far4;
  assign dx_c  = $signed(38'({x2, 16'h0000})) - 38'(cx);
  assign dy_c  = $signed(38'({y2, 16'h0000})) - 38'(cy);
  assign far_c = !(dx_c > -FAR_LIM && dx_c < FAR_LIM && dy_c > -FAR_LIM && dy_c < FAR_LIM);

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      dx3  <= dx_c[29:0];
      dy3  <= dy_c[29:0];
      far3 <= far_c;
      bg3  <= bg2;
    end
  end

  // squares
  logic signed [59:0] sqx, sqy;
  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      sqx  <= dx3 * dx3;
      sqy  <= dy3 * dy3;
      far4 <= far3;
      bg4  <= bg3;
    end
  end

  assign out_valid    = v4;
  assign out_data.d2  = adb_pkg::D2W'($unsigned(sqx)) + adb_pkg::D2W'($unsigned(sqy));
  assign out_data.far = far4;
  assign out_data.bg  = bg4;

endmodule

// File: rtl/core/adb_queue.sv
// ----------------------------------------------------------------------------
// adb_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module adb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  adb_pkg::q_entry_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output adb_pkg::q_entry_t rd_data
);

  adb_pkg::q_entry_t mem [adb_pkg::QDEPTH];
  logic [adb_pkg::QAW-1:0] wptr, rptr;
  logic [adb_pkg::QAW:0]   count;
  logic push, pop;

  assign wr_ready = count != (adb_pkg::QAW+1)'(adb_pkg::QDEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (adb_pkg::QAW+1)'(adb_pkg::QDEPTH))
    else $error("queue fill level beyond depth");
  a_push_only: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue fill level missed a push");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue fill level missed a pop");
`endif

endmodule

// File: rtl/core/adb_back.sv
// ----------------------------------------------------------------------------
// adb_back
// Pipelined square root, coverage and per channel blend.
// ----------------------------------------------------------------------------
module adb_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  adb_pkg::q_entry_t      in_data,
  input  logic [adb_pkg::RW-1:0] radius,
  input  logic [31:0]            color,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_pixel,
  output logic                   covered
);

  localparam int NS = adb_pkg::NS;

  logic              sq_v   [NS];
  logic              sq_rdy [NS];
  adb_pkg::sqrt_t    sq_st  [NS];
  logic              sq_far [NS];
  logic [31:0]       sq_bg  [NS];

  logic c1_v, c2_v, c3_v, c4_v, o_v;
  logic c1_rdy, c2_rdy, c3_rdy, c4_rdy, o_rdy;

  assign o_rdy  = !o_v || !out_stall;
  assign c4_rdy = !c4_v || o_rdy;
  assign c3_rdy = !c3_v || c4_rdy;
  assign c2_rdy = !c2_v || c3_rdy;
  assign c1_rdy = !c1_v || c2_rdy;
  assign in_ready = sq_rdy[0];

  // square root, one result bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic           pv;
    adb_pkg::sqrt_t pst;
    logic           pfar;
    logic [31:0]    pbg;
    if (k == 0) begin : g_first
      assign pv   = in_valid;
      assign pst  = '{rem: in_data.d2, res: '0};
      assign pfar = in_data.far;
      assign pbg  = in_data.bg;
    end else begin : g_next
      assign pv   = sq_v[k-1];
      assign pst  = sq_st[k-1];
      assign pfar = sq_far[k-1];
      assign pbg  = sq_bg[k-1];
    end
    if (k == NS - 1) begin : g_last
      assign sq_rdy[k] = !sq_v[k] || c1_rdy;
    end else begin : g_mid
      assign sq_rdy[k] = !sq_v[k] || sq_rdy[k+1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (sq_rdy[k]) begin
        sq_v[k] <= pv;
      end
    end
    always_ff @(posedge clk) begin
      if (sq_rdy[k] && pv) begin
        sq_st[k]  <= adb_pkg::isqrt_step(pst, k);
        sq_far[k] <= pfar;
        sq_bg[k]  <= pbg;
      end
    end
  end

  // coverage
  logic signed [31:0] cov_raw;
  logic [16:0]        cov1;
  logic               cv1, cv2, cv3, cv4;
  logic [31:0]        bg1, bg2, bg3, bg4;
  assign cov_raw = $signed(32'(radius)) + 32'sd32768
                 - $signed(32'(sq_st[NS-1].res[30:0]));

  always_ff @(posedge clk) begin
    if (c1_rdy && sq_v[NS-1]) begin
      cv1  <= !sq_far[NS-1] && (cov_raw > 32'sd0);
      cov1 <= (cov_raw > 32'sd65536) ? 17'd65536 : cov_raw[16:0];
      bg1  <= sq_bg[NS-1];
    end
  end

  // effective alpha
  logic [24:0] m2;
  always_ff @(posedge clk) begin
    if (c2_rdy && c1_v) begin
      m2  <= color[31:24] * cov1;
      cv2 <= cv1;
      bg2 <= bg1;
    end
  end

  // channel products
  logic signed [34:0] p3 [3];
  always_ff @(posedge clk) begin
    if (c3_rdy && c2_v) begin
      for (int i = 0; i < 3; i++) begin
        p3[i] <= ($signed({1'b0, color[8*i +: 8]}) - $signed({1'b0, bg2[8*i +: 8]}))
               * $signed({1'b0, m2});
      end
      cv3 <= cv2;
      bg3 <= bg2;
    end
  end

  // floor division by 255 through a reciprocal
  logic [7:0] t4 [3];
  logic       n4 [3];
  always_ff @(posedge clk) begin
    if (c4_rdy && c3_v) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [18:0] q;
        logic [16:0]        u;
        logic [33:0]        prod;
        q    = p3[i][34:16];
        u    = q[18] ? 17'(19'sd254 - q) : q[16:0];
        prod = 34'(u) * 34'd65794;
        t4[i] <= prod[31:24];
        n4[i] <= q[18];
      end
      cv4 <= cv3;
      bg4 <= bg3;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (o_rdy && c4_v) begin
      covered <= cv4;
      if (cv4) begin
        out_pixel[31:24] <= 8'hFF;
        for (int i = 0; i < 3; i++) begin
          out_pixel[8*i +: 8] <= n4[i] ? bg4[8*i +: 8] - t4[i] : bg4[8*i +: 8] + t4[i];
        end
      end else begin
        out_pixel <= bg4;
      end
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      c3_v <= 1'b0;
      c4_v <= 1'b0;
      o_v  <= 1'b0;
    end else begin
      if (c1_rdy) c1_v <= sq_v[NS-1];
      if (c2_rdy) c2_v <= c1_v;
      if (c3_rdy) c3_v <= c2_v;
      if (c4_rdy) c4_v <= c3_v;
      if (o_rdy)  o_v  <= c4_v;
    end
  end

  assign out_valid = o_v;

endmodule

// File: rtl/core/antialiased_disc_blend.sv
// ----------------------------------------------------------------------------
// antialiased_disc_blend
// Composites one interpolated antialiased disc over a pixel stream.
// ----------------------------------------------------------------------------
// One pixel word is taken per clock and one result word leaves per clock in
// steady state while out_stall is low. A result word passes four front stages,
// one queue slot, the 30 stage square root of the squared distance and five
// blend stages. A four word queue sits between the distance front end and the
// root and blend back end. Register writes are taken at any time but must only
// be made while no pixel is in flight.
module antialiased_disc_blend #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [31:0]           background,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_pixel,
  output logic                  covered,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  adb_pkg::cfg_t            cfg;
  adb_pkg::q_entry_t        fq_data, qb_data;
  logic                     fq_valid, fq_ready, qb_valid, qb_ready;
  logic [adb_pkg::RW-1:0]   radius;

  assign cfg_ready = 1'b1;

  // register bank
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prev_cx  <= '0;
      cfg.prev_cy  <= '0;
      cfg.prev_r   <= 16'(1 << FRAC_BITS);
      cfg.cur_cx   <= '0;
      cfg.cur_cy   <= '0;
      cfg.cur_r    <= 16'(1 << FRAC_BITS);
      cfg.fraction <= '0;
      cfg.color    <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (adb_pkg::reg_index_t'(cfg_index))
        adb_pkg::REG_PREV_CX:  cfg.prev_cx  <= cfg_data[20:0];
        adb_pkg::REG_PREV_CY:  cfg.prev_cy  <= cfg_data[20:0];
        adb_pkg::REG_PREV_R:   cfg.prev_r   <= cfg_data[15:0];
        adb_pkg::REG_CUR_CX:   cfg.cur_cx   <= cfg_data[20:0];
        adb_pkg::REG_CUR_CY:   cfg.cur_cy   <= cfg_data[20:0];
        adb_pkg::REG_CUR_R:    cfg.cur_r    <= cfg_data[15:0];
        adb_pkg::REG_FRACTION: cfg.fraction <= cfg_data[8:0];
        adb_pkg::REG_COLOR:    cfg.color    <= cfg_data;
        default: ;
      endcase
    end
  end

  adb_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .background (background),
    .cfg        (cfg),
    .radius     (radius),
    .out_valid  (fq_valid),
    .out_ready  (fq_ready),
    .out_data   (fq_data)
  );

  adb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  adb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (qb_valid),
    .in_ready  (qb_ready),
    .in_data   (qb_data),
    .radius    (radius),
    .color     (cfg.color),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel),
    .covered   (covered)
  );

endmodule
